### hdl/ispb_pkg.sv
// shared types, constants and blend arithmetic for the ink-spread pixel blend core
// no dependencies; modules use scoped names into it, the testbench imports it

package ispb_pkg;

  localparam int SideDefault = 128;
  localparam int RowFieldW   = 7;
  localparam int ColourW     = 8;
  localparam int CountW      = 4;
  localparam int NumW        = 12;
  localparam int ProdW       = 25;

  localparam logic [CountW-1:0]  CountMax     = 4'd15;
  localparam logic [CountW-1:0]  OpacitySteps = 4'd10;
  localparam logic [ColourW-1:0] White        = 8'd255;

  // floor(v/10) == (v*6554)>>16 for every v up to 2550
  localparam int RecipTen      = 6554;
  localparam int RecipTenShift = 16;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic {
    VisitSeed   = 1'b0,
    VisitSpread = 1'b1
  } visit_kind_e;

  typedef struct packed {
    visit_kind_e            kind;
    logic [RowFieldW-1:0]   row;
    logic [RowFieldW-1:0]   col;
    logic [ColourW-1:0]     src_blue;
    logic [ColourW-1:0]     src_green;
    logic [ColourW-1:0]     src_red;
    logic                   coin;
  } in_item_t;

  typedef struct packed {
    logic                   written;
    logic [ColourW-1:0]     out_blue;
    logic [ColourW-1:0]     out_green;
    logic [ColourW-1:0]     out_red;
  } out_item_t;

  // numerator src*k + 255*(10-k), at most 2550
  function automatic logic [NumW-1:0] blend_num(input logic [ColourW-1:0] src,
                                                 input count_t k);
    blend_num = NumW'(src) * NumW'(k) + NumW'(White) * NumW'(OpacitySteps - k);
  endfunction

  function automatic logic [ColourW-1:0] div_ten(input logic [NumW-1:0] v);
    logic [ProdW-1:0] p;
    p = ProdW'(v) * ProdW'(RecipTen);
    return p[RecipTenShift +: ColourW];
  endfunction

endpackage

### hdl/ispb_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
// payload type is given by the instantiating code

interface ispb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/ink_spread_pixel_blend_core.sv
// top level of the ink-spread pixel blend: read stage, decide/write-back stage, output register
// uses ispb_pkg, ispb_stream_if, ispb_cnt_mem, ispb_flag_mem and ispb_clear

// Takes one pixel visit per clock cycle while the result side keeps taking; each
// visit passes the stage 1 registers, then the output register. The paint counts live
// in a row-wide count memory and a row-wide painted-flag memory; in the cycle a visit
// is taken, row r of the counts and rows r-1 and r+1 of the flags are read; in the
// cycle after, the neighbour test and the blend numerator are worked out, and a
// painted pixel's count row is written back as it moves on. A bypass register keeps
// the latest written row so that a visit right behind it sees its counts.
// After reset a clearing pass zeroes both memories one row per cycle, taking no visit.

module ink_spread_pixel_blend_core #(
  parameter int Side = ispb_pkg::SideDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ispb_stream_if.sink          in_i,
  ispb_stream_if.source        out_o
);

  localparam int RowW   = $clog2(Side);
  localparam int ExtW   = RowW + ispb_pkg::RowFieldW;
  localparam int CountW = ispb_pkg::CountW;
  localparam logic [RowW-1:0] LastIdx = RowW'(Side - 1);

  typedef logic [Side-1:0][CountW-1:0] cnt_row_t;

  // input side
  logic            accept;
  logic [ExtW-1:0] row_ext, col_ext;
  logic [RowW-1:0] row_w, col_w, up_row_w, dn_row_w;
  logic            in_range_w;

  // clearing pass
  logic            clr_busy;
  logic [RowW-1:0] clr_row;

  // stage 1
  logic                 s1_valid_q, s1_valid_d;
  ispb_pkg::in_item_t   s1_item_q;
  logic [RowW-1:0]      s1_row_q, s1_col_q, s1_up_q, s1_dn_q;
  logic                 s1_in_range_q;
  logic                 s1_adv;

  // memory read data
  cnt_row_t         cnt_rd;
  logic [Side-1:0]  up_rd, dn_rd;

  // bypass of the most recent row write
  logic             fwd_valid_q;
  logic [RowW-1:0]  fwd_row_q;
  cnt_row_t         fwd_cnt_q;
  logic [Side-1:0]  fwd_flags;

  // stage 1 decision
  cnt_row_t                 cnt_row, new_row;
  logic [Side-1:0]          up_flags, dn_flags, new_flags;
  logic [RowW-1:0]          left_idx, right_idx;
  ispb_pkg::count_t         self_cnt, self_inc, k_eff;
  logic                     nb_painted, paint, item_wr_en;
  logic [ispb_pkg::NumW-1:0] num_b, num_g, num_r;

  // memory write port
  logic             mem_wr_en;
  logic [RowW-1:0]  mem_wr_row;
  cnt_row_t         mem_wr_cnt;
  logic [Side-1:0]  mem_wr_flags;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic                      out_written_q;
  logic [ispb_pkg::NumW-1:0] out_num_b_q, out_num_g_q, out_num_r_q;

  // ---------------------------------------------------------------- input side
  assign row_ext    = ExtW'(in_i.data.row);
  assign col_ext    = ExtW'(in_i.data.col);
  assign in_range_w = (row_ext < ExtW'(Side)) && (col_ext < ExtW'(Side));
  assign row_w      = row_ext[RowW-1:0];
  assign col_w      = col_ext[RowW-1:0];
  assign up_row_w   = (row_w == '0)      ? row_w : row_w - RowW'(1);
  assign dn_row_w   = (row_w == LastIdx) ? row_w : row_w + RowW'(1);

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clr_busy && (!s1_valid_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  ispb_clear #(.Side(Side)) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .row_o  (clr_row)
  );

  ispb_cnt_mem #(.Side(Side)) u_cnt_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_row_i  (row_w),
    .rd_data_o (cnt_rd),
    .wr_en_i   (mem_wr_en),
    .wr_row_i  (mem_wr_row),
    .wr_data_i (mem_wr_cnt)
  );

  ispb_flag_mem #(.Side(Side)) u_flag_mem (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_a_row_i  (up_row_w),
    .rd_b_row_i  (dn_row_w),
    .rd_a_data_o (up_rd),
    .rd_b_data_o (dn_rd),
    .wr_en_i     (mem_wr_en),
    .wr_row_i    (mem_wr_row),
    .wr_data_i   (mem_wr_flags)
  );

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q     <= in_i.data;
      s1_row_q      <= row_w;
      s1_col_q      <= col_w;
      s1_up_q       <= up_row_w;
      s1_dn_q       <= dn_row_w;
      s1_in_range_q <= in_range_w;
    end
  end

  always_comb begin
    for (int i = 0; i < Side; i++) begin
      fwd_flags[i] = |fwd_cnt_q[i];
    end
  end

  // the row written on the edge that also latched the read is not in the read data
  assign cnt_row  = (fwd_valid_q && fwd_row_q == s1_row_q) ? fwd_cnt_q : cnt_rd;
  assign up_flags = (fwd_valid_q && fwd_row_q == s1_up_q)  ? fwd_flags : up_rd;
  assign dn_flags = (fwd_valid_q && fwd_row_q == s1_dn_q)  ? fwd_flags : dn_rd;

  assign left_idx  = (s1_col_q == '0)      ? s1_col_q : s1_col_q - RowW'(1);
  assign right_idx = (s1_col_q == LastIdx) ? s1_col_q : s1_col_q + RowW'(1);

  assign nb_painted = ((s1_row_q != '0)      && up_flags[s1_col_q])
                   || ((s1_row_q != LastIdx) && dn_flags[s1_col_q])
                   || ((s1_col_q != '0)      && (cnt_row[left_idx] != '0))
                   || ((s1_col_q != LastIdx) && (cnt_row[right_idx] != '0));

  assign self_cnt = cnt_row[s1_col_q];
  assign self_inc = (self_cnt == ispb_pkg::CountMax) ? self_cnt : self_cnt + CountW'(1);

  assign paint = s1_in_range_q
              && ((s1_item_q.kind == ispb_pkg::VisitSeed) || (s1_item_q.coin && nb_painted));

  // a seed passes the source through, which is the blend at full opacity
  always_comb begin
    if (s1_item_q.kind == ispb_pkg::VisitSeed || self_cnt > ispb_pkg::OpacitySteps) begin
      k_eff = ispb_pkg::OpacitySteps;
    end else begin
      k_eff = self_cnt;
    end
  end

  assign num_b = paint ? ispb_pkg::blend_num(s1_item_q.src_blue,  k_eff) : '0;
  assign num_g = paint ? ispb_pkg::blend_num(s1_item_q.src_green, k_eff) : '0;
  assign num_r = paint ? ispb_pkg::blend_num(s1_item_q.src_red,   k_eff) : '0;

  always_comb begin
    new_row           = cnt_row;
    new_row[s1_col_q] = self_inc;
    for (int i = 0; i < Side; i++) begin
      new_flags[i] = |new_row[i];
    end
  end

  assign item_wr_en = s1_adv && paint;

  always_comb begin
    if (clr_busy) begin
      mem_wr_en    = 1'b1;
      mem_wr_row   = clr_row;
      mem_wr_cnt   = '0;
      mem_wr_flags = '0;
    end else begin
      mem_wr_en    = item_wr_en;
      mem_wr_row   = s1_row_q;
      mem_wr_cnt   = new_row;
      mem_wr_flags = new_flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (item_wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_wr_en) begin
      fwd_row_q <= s1_row_q;
      fwd_cnt_q <= new_row;
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_written_q <= paint;
      out_num_b_q   <= num_b;
      out_num_g_q   <= num_g;
      out_num_r_q   <= num_r;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.written   = out_written_q;
  assign out_o.data.out_blue  = ispb_pkg::div_ten(out_num_b_q);
  assign out_o.data.out_green = ispb_pkg::div_ten(out_num_g_q);
  assign out_o.data.out_red   = ispb_pkg::div_ten(out_num_r_q);

  // ---------------------------------------------------------------- assertions
  a_no_item_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(clr_busy && s1_valid_q)
  ) else $error("visit in flight during clearing pass");

  a_advance_fills_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q
  ) else $error("advanced visit did not reach the output register");

  a_paint_leaves_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    item_wr_en |-> (self_inc != '0) && (self_inc >= self_cnt)
  ) else $error("painted pixel count did not grow or saturate");

  a_seed_written: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_in_range_q && s1_item_q.kind == ispb_pkg::VisitSeed) |=> out_written_q
  ) else $error("seed visit not marked written");

endmodule

### hdl/ispb_cnt_mem.sv
// paint count store, one row of counts per word, one read and one write port
// uses ispb_pkg for the count width

module ispb_cnt_mem #(
  parameter int Side = ispb_pkg::SideDefault,
  localparam int RowW = $clog2(Side)
) (
  input  logic                                   clk_i,
  input  logic                                   rd_en_i,
  input  logic [RowW-1:0]                        rd_row_i,
  output logic [Side-1:0][ispb_pkg::CountW-1:0]  rd_data_o,
  input  logic                                   wr_en_i,
  input  logic [RowW-1:0]                        wr_row_i,
  input  logic [Side-1:0][ispb_pkg::CountW-1:0]  wr_data_i
);

  logic [Side-1:0][ispb_pkg::CountW-1:0] mem_q [Side];
  logic [Side-1:0][ispb_pkg::CountW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/ispb_flag_mem.sv
// painted flags, one row bitmap per word, two read ports and one write port
// serves the rows above and below the visited pixel

module ispb_flag_mem #(
  parameter int Side = ispb_pkg::SideDefault,
  localparam int RowW = $clog2(Side)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [RowW-1:0]  rd_a_row_i,
  input  logic [RowW-1:0]  rd_b_row_i,
  output logic [Side-1:0]  rd_a_data_o,
  output logic [Side-1:0]  rd_b_data_o,
  input  logic             wr_en_i,
  input  logic [RowW-1:0]  wr_row_i,
  input  logic [Side-1:0]  wr_data_i
);

  logic [Side-1:0] mem_q [Side];
  logic [Side-1:0] rd_a_data_q;
  logic [Side-1:0] rd_b_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_data_q <= mem_q[rd_a_row_i];
      rd_b_data_q <= mem_q[rd_b_row_i];
    end
  end

  assign rd_a_data_o = rd_a_data_q;
  assign rd_b_data_o = rd_b_data_q;

endmodule

### hdl/ispb_clear.sv
// post-reset sweep that zeroes both stores one row per cycle
// no package dependencies beyond the default side length

module ispb_clear #(
  parameter int Side = ispb_pkg::SideDefault,
  localparam int RowW = $clog2(Side)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  output logic [RowW-1:0]  row_o
);

  localparam logic [RowW-1:0] LastIdx = RowW'(Side - 1);

  logic            busy_q, busy_d;
  logic [RowW-1:0] row_q, row_d;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (busy_q) begin
      if (row_q == LastIdx) begin
        busy_d = 1'b0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  assign busy_o = busy_q;
  assign row_o  = row_q;

endmodule

### tb/tb_ink_spread_pixel_blend_core.sv
// self-checking testbench for ink_spread_pixel_blend_core: directed border and saturation
// visits, then clustered and scattered random visits; depends on ispb_pkg and ispb_stream_if

module tb_ink_spread_pixel_blend_core;
  import ispb_pkg::*;

  localparam int Side = SideDefault;

  logic clk_i;
  logic rst_ni;

  ispb_stream_if #(.T(in_item_t))  visit_ch ();
  ispb_stream_if #(.T(out_item_t)) pixel_ch ();

  ink_spread_pixel_blend_core #(
    .Side(Side)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (visit_ch),
    .out_o (pixel_ch)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // own copy of the per-pixel paint counts
  count_t    paint_cnt [Side*Side];
  out_item_t expected_pixels [$];

  int errors;
  int src_idle_pct;
  int sink_idle_pct;
  int stall_left;
  int n_seed;
  int n_painted;
  int n_unpainted;
  int n_sat_hits;
  int n_full_opacity;
  int clu_r;
  int clu_c;

  function automatic logic [ColourW-1:0] mix_with_white(logic [ColourW-1:0] src,
                                                        int unsigned k);
    int unsigned num;
    num = 32'(src) * k + 32'(White) * (32'(OpacitySteps) - k);
    return ColourW'(num / 32'(OpacitySteps));
  endfunction

  function automatic void bump_count(int idx);
    if (paint_cnt[idx] != CountMax) begin
      paint_cnt[idx] = paint_cnt[idx] + CountW'(1);
    end else begin
      n_sat_hits++;
    end
  endfunction

  function automatic out_item_t predict_visit(in_item_t v);
    out_item_t   res;
    int          r;
    int          c;
    int          idx;
    int unsigned k;
    bit          near;
    res = '0;
    r   = int'(v.row);
    c   = int'(v.col);
    if (r >= Side || c >= Side) begin
      n_unpainted++;
      return res;
    end
    idx = r * Side + c;
    if (v.kind == VisitSeed) begin
      bump_count(idx);
      res.written   = 1'b1;
      res.out_blue  = v.src_blue;
      res.out_green = v.src_green;
      res.out_red   = v.src_red;
      n_seed++;
      return res;
    end
    near = 1'b0;
    if (r > 0 && paint_cnt[idx-Side] != 0) near = 1'b1;
    if (r + 1 < Side && paint_cnt[idx+Side] != 0) near = 1'b1;
    if (c > 0 && paint_cnt[idx-1] != 0) near = 1'b1;
    if (c + 1 < Side && paint_cnt[idx+1] != 0) near = 1'b1;
    if (v.coin && near) begin
      k = 32'(paint_cnt[idx]);
      if (k >= 32'(OpacitySteps)) begin
        k = 32'(OpacitySteps);
        n_full_opacity++;
      end
      res.written   = 1'b1;
      res.out_blue  = mix_with_white(v.src_blue, k);
      res.out_green = mix_with_white(v.src_green, k);
      res.out_red   = mix_with_white(v.src_red, k);
      bump_count(idx);
      n_painted++;
    end else begin
      n_unpainted++;
    end
    return res;
  endfunction

  // expectation pushed in transfer order at the input side
  always @(posedge clk_i) begin
    if (rst_ni && visit_ch.valid && visit_ch.ready) begin
      expected_pixels.push_back(predict_visit(visit_ch.data));
    end
  end

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_pixel
    out_item_t want;
    out_item_t got;
    if (rst_ni && pixel_ch.valid && pixel_ch.ready) begin
      got = pixel_ch.data;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        report_field("written", int'(want.written), int'(got.written));
        report_field("out_blue", int'(want.out_blue), int'(got.out_blue));
        report_field("out_green", int'(want.out_green), int'(got.out_green));
        report_field("out_red", int'(want.out_red), int'(got.out_red));
      end
    end
  end

  // result side stalls in random bursts whose start is governed by sink_idle_pct
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_ch.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left != 0) begin
      pixel_ch.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      pixel_ch.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 8);
    end else begin
      pixel_ch.ready <= 1'b1;
    end
  end

  function automatic in_item_t visit(visit_kind_e kind, int r, int c, int b, int g,
                                     int rd, bit coin);
    in_item_t v;
    v.kind      = kind;
    v.row       = RowFieldW'(r);
    v.col       = RowFieldW'(c);
    v.src_blue  = ColourW'(b);
    v.src_green = ColourW'(g);
    v.src_red   = ColourW'(rd);
    v.coin      = coin;
    return v;
  endfunction

  // one transfer; called at a rising edge, returns at the edge where it was taken
  task automatic send_visit(in_item_t v);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      visit_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    visit_ch.data  <= v;
    visit_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!visit_ch.ready) @(posedge clk_i);
  endtask

  task automatic test_corner_seeds();
    send_visit(visit(VisitSeed, 0, 0, 0, 0, 0, 1'b0));
    send_visit(visit(VisitSeed, 0, Side-1, 255, 255, 255, 1'b1));
    send_visit(visit(VisitSeed, Side-1, 0, 255, 0, 128, 1'b0));
    send_visit(visit(VisitSeed, Side-1, Side-1, 1, 254, 127, 1'b1));
  endtask

  task automatic test_border_spreads();
    send_visit(visit(VisitSpread, Side-2, Side-1, 17, 200, 99, 1'b1));
    // painted neighbour above but coin clear
    send_visit(visit(VisitSpread, 1, Side-1, 50, 60, 70, 1'b0));
    // nothing painted nearby
    send_visit(visit(VisitSpread, Side/2, Side/2, 255, 255, 255, 1'b1));
    send_visit(visit(VisitSpread, Side-1, Side-2, 0, 0, 0, 1'b1));
  endtask

  // pixel next to a corner seed painted over and over, past full opacity and count limit
  task automatic test_count_saturation();
    for (int i = 0; i < 17; i++) begin
      case (i % 3)
        0:       send_visit(visit(VisitSpread, 0, 1, 0, 0, 0, 1'b1));
        1:       send_visit(visit(VisitSpread, 0, 1, 255, 255, 255, 1'b1));
        default: send_visit(visit(VisitSpread, 0, 1, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255), 1'b1));
      endcase
    end
  endtask

  function automatic int pick_base();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return Side - 4;
      default: return $urandom_range(0, Side - 4);
    endcase
  endfunction

  function automatic in_item_t scattered_visit();
    in_item_t v;
    v.kind      = $urandom_range(0, 1) ? VisitSpread : VisitSeed;
    v.row       = RowFieldW'($urandom);
    v.col       = RowFieldW'($urandom);
    v.src_blue  = ColourW'($urandom);
    v.src_green = ColourW'($urandom);
    v.src_red   = ColourW'($urandom);
    v.coin      = 1'($urandom_range(0, 1));
    return v;
  endfunction

  // visits packed into a small moving window so counts build up and spread
  function automatic in_item_t clustered_visit();
    in_item_t v;
    if ($urandom_range(0, 23) == 0) begin
      clu_r = pick_base();
      clu_c = pick_base();
    end
    v       = scattered_visit();
    v.kind  = ($urandom_range(0, 3) == 0) ? VisitSeed : VisitSpread;
    v.row   = RowFieldW'(clu_r + $urandom_range(0, 3));
    v.col   = RowFieldW'(clu_c + $urandom_range(0, 3));
    v.coin  = ($urandom_range(0, 4) != 0);
    return v;
  endfunction

  task automatic test_random_clusters(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_visit(scattered_visit());
      else send_visit(clustered_visit());
    end
  endtask

  task automatic test_random_scatter(int n);
    for (int i = 0; i < n; i++) send_visit(scattered_visit());
  endtask

  initial begin
    foreach (paint_cnt[i]) paint_cnt[i] = '0;
    errors         = 0;
    n_seed         = 0;
    n_painted      = 0;
    n_unpainted    = 0;
    n_sat_hits     = 0;
    n_full_opacity = 0;
    clu_r          = pick_base();
    clu_c          = pick_base();
    src_idle_pct   = 25;
    sink_idle_pct  = 25;
    rst_ni         <= 1'b0;
    visit_ch.valid <= 1'b0;
    visit_ch.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_seeds();
    test_border_spreads();
    test_count_saturation();
    test_random_clusters(500);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_clusters(150);
    src_idle_pct  = 30;
    sink_idle_pct = 40;
    test_random_scatter(200);
    test_random_clusters(100);
    // closing stretch at full rate on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_clusters(250);
    visit_ch.valid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("visits: %0d seeds, %0d painted spreads, %0d spreads left unpainted",
             n_seed, n_painted, n_unpainted);
    $display("blends at full opacity: %0d, bumps held at the count limit: %0d",
             n_full_opacity, n_sat_hits);
    if (errors == 0) begin
      $display("tb_ink_spread_pixel_blend_core: done, clean");
    end else begin
      $display("tb_ink_spread_pixel_blend_core: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_pixels.size());
    $display("tb_ink_spread_pixel_blend_core: done, errors");
    $finish;
  end

endmodule
